>>> design/ebpf_pkg.sv
`timescale 1ns / 1ps
package ebpf_pkg;
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_CALL    = 2'd2;
   localparam logic [1:0] ST_EXIT    = 2'd3;

   localparam logic [7:0] OPC_LDDW = 8'h18;
   localparam logic [7:0] OPC_CALL = 8'h85;
   localparam logic [7:0] OPC_EXIT = 8'h95;

   localparam logic [2:0] CLS_LD    = 3'd0;
   localparam logic [2:0] CLS_ALU   = 3'd4;
   localparam logic [2:0] CLS_JMP   = 3'd5;
   localparam logic [2:0] CLS_ALU64 = 3'd7;

   localparam logic [3:0] OPR_ADD  = 4'h0;
   localparam logic [3:0] OPR_SUB  = 4'h1;
   localparam logic [3:0] OPR_MUL  = 4'h2;
   localparam logic [3:0] OPR_DIV  = 4'h3;
   localparam logic [3:0] OPR_OR   = 4'h4;
   localparam logic [3:0] OPR_AND  = 4'h5;
   localparam logic [3:0] OPR_LSH  = 4'h6;
   localparam logic [3:0] OPR_RSH  = 4'h7;
   localparam logic [3:0] OPR_NEG  = 4'h8;
   localparam logic [3:0] OPR_MOD  = 4'h9;
   localparam logic [3:0] OPR_XOR  = 4'hA;
   localparam logic [3:0] OPR_MOV  = 4'hB;
   localparam logic [3:0] OPR_ARSH = 4'hC;

   localparam logic [3:0] JOP_JA   = 4'h0;
   localparam logic [3:0] JOP_JEQ  = 4'h1;
   localparam logic [3:0] JOP_JGT  = 4'h2;
   localparam logic [3:0] JOP_JGE  = 4'h3;
   localparam logic [3:0] JOP_JSET = 4'h4;
   localparam logic [3:0] JOP_JNE  = 4'h5;
   localparam logic [3:0] JOP_JSGT = 4'h6;
   localparam logic [3:0] JOP_JSGE = 4'h7;
   localparam logic [3:0] JOP_JLT  = 4'hA;
   localparam logic [3:0] JOP_JLE  = 4'hB;
   localparam logic [3:0] JOP_JSLT = 4'hC;
   localparam logic [3:0] JOP_JSLE = 4'hD;

   typedef struct packed {
      logic        op;
      logic [7:0]  opcode;
      logic [3:0]  dst_reg;
      logic [3:0]  src_reg;
      logic [15:0] offset;
      logic [31:0] immediate;
      logic [31:0] immediate_high;
      logic [63:0] write_value;
   } req_type;
endpackage

>>> design/ebpf_alu_branch_execute.sv
`timescale 1ns / 1ps
// eBPF execute unit: one transaction is either a host register write (op=1) or one
// decoded instruction (op=0) run against a NUM_REGS x 64-bit register file held in a
// synchronous memory plus a separate copy of r0 for return_value. Each transaction
// passes a read state (dst and src read from two memory ports) and an execute state
// that writes back and loads the response register; the response then waits in its
// own state until taken, and no new request is accepted meanwhile. A simple
// transaction goes through accept, read, execute and response in turn. DIV and MOD
// with a nonzero divisor run on a radix-2 divider and then a second execute pass.
// MUL sums three 32x32 partial products, one per cycle, and then takes a second
// execute pass. Registers reset to zero through valid bits; unwritten entries read
// as zero. Loads other than LDDW, stores and JMP32 report illegal; call reports
// status 2 with the immediate as call_number.
module ebpf_alu_branch_execute #(
   parameter int NUM_REGS = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [7:0]         req_opcode,
   input  logic [3:0]         req_dst_reg,
   input  logic [3:0]         req_src_reg,
   input  logic signed [15:0] req_offset,
   input  logic signed [31:0] req_immediate,
   input  logic [31:0]        req_immediate_high,
   input  logic [63:0]        req_write_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_branch_taken,
   output logic signed [16:0] rsp_pc_step,
   output logic signed [31:0] rsp_call_number,
   output logic [63:0]        rsp_return_value
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   ebpf_pkg::req_type req_ff;

   // register file memory, two read ports
   logic [63:0] rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_vld_ff;
   logic [63:0] rd_d_ff, rd_s_ff;
   logic vd_ff, vs_ff;
   logic [63:0] r0_ff;
   logic        wr_en;
   logic [3:0]  wr_idx;
   logic [63:0] wr_data;

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_d_ff <= rf_mem[req_ff.dst_reg[$clog2(NUM_REGS)-1:0]];
         rd_s_ff <= rf_mem[req_ff.src_reg[$clog2(NUM_REGS)-1:0]];
         vd_ff   <= rf_vld_ff[req_ff.dst_reg[$clog2(NUM_REGS)-1:0]];
         vs_ff   <= rf_vld_ff[req_ff.src_reg[$clog2(NUM_REGS)-1:0]];
      end
      if (wr_en) rf_mem[wr_idx[$clog2(NUM_REGS)-1:0]] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
         r0_ff     <= '0;
      end else if (wr_en) begin
         rf_vld_ff[wr_idx[$clog2(NUM_REGS)-1:0]] <= 1'b1;
         if (wr_idx == 4'd0) r0_ff <= wr_data;
      end
   end

   // decode of the held transaction
   logic [2:0] cls;
   logic [3:0] opr;
   logic       use_src, dst_ok, src_ok;
   assign cls     = req_ff.opcode[2:0];
   assign opr     = req_ff.opcode[7:4];
   assign use_src = req_ff.opcode[3];
   assign dst_ok  = {28'd0, req_ff.dst_reg} < NUM_REGS;
   assign src_ok  = !use_src || ({28'd0, req_ff.src_reg} < NUM_REGS);

   logic [63:0] d_val, s_val, imm64;
   assign imm64 = {{32{req_ff.immediate[31]}}, req_ff.immediate};
   assign d_val = vd_ff ? rd_d_ff : 64'd0;
   assign s_val = use_src ? (vs_ff ? rd_s_ff : 64'd0) : imm64;

   // multiplier: three 32x32 partials, one per cycle (high x high lies above bit 63)
   logic [1:0]  mcnt_ff;
   logic [63:0] macc_ff;
   logic [63:0] mprod;
   always_comb begin
      case (mcnt_ff)
         2'd0:    mprod = d_val[31:0] * s_val[31:0];
         2'd1:    mprod = d_val[63:32] * s_val[31:0];
         default: mprod = d_val[31:0] * s_val[63:32];
      endcase
   end

   // restoring divider, one quotient bit per cycle
   logic [6:0]  dcnt_ff;
   logic [63:0] quo_ff, rem_ff;
   logic [64:0] rem_sh, rem_sub;
   assign rem_sh  = {rem_ff, quo_ff[63]};
   assign rem_sub = rem_sh - {1'b0, s_val};

   logic        is_alu, is_muldiv, alu_known;
   assign is_alu    = (cls == ebpf_pkg::CLS_ALU) || (cls == ebpf_pkg::CLS_ALU64);
   assign alu_known = opr <= ebpf_pkg::OPR_ARSH;
   assign is_muldiv = is_alu && dst_ok && src_ok && !req_ff.op &&
                      ((opr == ebpf_pkg::OPR_MUL) ||
                       (((opr == ebpf_pkg::OPR_DIV) || (opr == ebpf_pkg::OPR_MOD)) &&
                        (s_val != 64'd0)));

   // result path
   logic [63:0] alu_r;
   logic [5:0]  sh;
   assign sh = s_val[5:0];
   always_comb begin
      case (opr)
         ebpf_pkg::OPR_ADD:  alu_r = d_val + s_val;
         ebpf_pkg::OPR_SUB:  alu_r = d_val - s_val;
         ebpf_pkg::OPR_MUL:  alu_r = macc_ff;
         ebpf_pkg::OPR_DIV:  alu_r = (s_val == 64'd0) ? 64'd0 : quo_ff;
         ebpf_pkg::OPR_OR:   alu_r = d_val | s_val;
         ebpf_pkg::OPR_AND:  alu_r = d_val & s_val;
         ebpf_pkg::OPR_LSH:  alu_r = d_val << sh;
         ebpf_pkg::OPR_RSH:  alu_r = d_val >> sh;
         ebpf_pkg::OPR_NEG:  alu_r = 64'd0 - d_val;
         ebpf_pkg::OPR_MOD:  alu_r = (s_val == 64'd0) ? d_val : rem_ff;
         ebpf_pkg::OPR_XOR:  alu_r = d_val ^ s_val;
         ebpf_pkg::OPR_MOV:  alu_r = s_val;
         ebpf_pkg::OPR_ARSH: alu_r = $unsigned($signed(d_val) >>> sh);
         default:            alu_r = 64'd0;
      endcase
   end

   logic cond, cond_known, eq, ult, slt;
   assign eq  = d_val == s_val;
   assign ult = d_val < s_val;
   assign slt = $signed(d_val) < $signed(s_val);
   always_comb begin
      cond_known = 1'b1;
      case (opr)
         ebpf_pkg::JOP_JEQ:  cond = eq;
         ebpf_pkg::JOP_JGT:  cond = !ult && !eq;
         ebpf_pkg::JOP_JGE:  cond = !ult;
         ebpf_pkg::JOP_JSET: cond = (d_val & s_val) != 64'd0;
         ebpf_pkg::JOP_JNE:  cond = !eq;
         ebpf_pkg::JOP_JSGT: cond = !slt && !eq;
         ebpf_pkg::JOP_JSGE: cond = !slt;
         ebpf_pkg::JOP_JLT:  cond = ult;
         ebpf_pkg::JOP_JLE:  cond = ult || eq;
         ebpf_pkg::JOP_JSLT: cond = slt;
         ebpf_pkg::JOP_JSLE: cond = slt || eq;
         default: begin
            cond       = 1'b0;
            cond_known = 1'b0;
         end
      endcase
   end

   logic signed [16:0] off_step;
   assign off_step = 17'($signed(req_ff.offset)) + 17'sd1;

   logic [1:0]         st;
   logic               tk;
   logic signed [16:0] step;
   logic [31:0]        cno;
   always_comb begin
      st      = ebpf_pkg::ST_ILLEGAL;
      tk      = 1'b0;
      step    = 17'sd0;
      cno     = 32'd0;
      wr_en   = 1'b0;
      wr_idx  = req_ff.dst_reg;
      wr_data = req_ff.write_value;
      if (req_ff.op) begin
         if (dst_ok) begin
            wr_en = 1'b1;
            st    = ebpf_pkg::ST_OK;
         end
      end else if (req_ff.opcode == ebpf_pkg::OPC_CALL) begin
         st   = ebpf_pkg::ST_CALL;
         step = 17'sd1;
         cno  = req_ff.immediate;
      end else if (req_ff.opcode == ebpf_pkg::OPC_EXIT) begin
         st = ebpf_pkg::ST_EXIT;
      end else if (cls == ebpf_pkg::CLS_JMP && opr == ebpf_pkg::JOP_JA) begin
         st   = ebpf_pkg::ST_OK;
         tk   = 1'b1;
         step = off_step;
      end else if (cls == ebpf_pkg::CLS_LD) begin
         if (req_ff.opcode == ebpf_pkg::OPC_LDDW && dst_ok) begin
            wr_en   = 1'b1;
            wr_data = {req_ff.immediate_high, req_ff.immediate};
            st      = ebpf_pkg::ST_OK;
            step    = 17'sd2;
         end
      end else if (dst_ok && src_ok) begin
         if (cls == ebpf_pkg::CLS_JMP) begin
            if (cond_known) begin
               st   = ebpf_pkg::ST_OK;
               tk   = cond;
               step = cond ? off_step : 17'sd1;
            end
         end else if (is_alu && alu_known) begin
            wr_en   = 1'b1;
            wr_data = (cls == ebpf_pkg::CLS_ALU) ? {32'd0, alu_r[31:0]} : alu_r;
            st      = ebpf_pkg::ST_OK;
            step    = 17'sd1;
         end
      end
      // write back only on the final execute cycle
      if (state_ff != S_EXEC || (is_muldiv && !started_ff)) wr_en = 1'b0;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: state_in = S_DONE;
         S_MUL:  if (mcnt_ff == 2'd2) state_in = S_EXEC;
         S_DIV:  if (dcnt_ff == 7'd63) state_in = S_EXEC;
         S_DONE: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // multi-cycle ops detour after a first execute pass and before the final one
      if (state_ff == S_READ) begin
         state_in = S_EXEC;
      end
   end

   logic started_ff;
   logic [2:0] state_nx;
   always_comb begin
      state_nx = state_in;
      if (state_ff == S_EXEC && is_muldiv && !started_ff)
         state_nx = (opr == ebpf_pkg::OPR_MUL) ? S_MUL : S_DIV;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_nx;
         if (state_ff == S_READ) started_ff <= 1'b0;
         else if (state_ff == S_MUL || state_ff == S_DIV) started_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.op             <= req_op;
         req_ff.opcode         <= req_opcode;
         req_ff.dst_reg        <= req_dst_reg;
         req_ff.src_reg        <= req_src_reg;
         req_ff.offset         <= req_offset;
         req_ff.immediate      <= req_immediate;
         req_ff.immediate_high <= req_immediate_high;
         req_ff.write_value    <= req_write_value;
      end
      if (state_ff == S_EXEC && is_muldiv && !started_ff) begin
         mcnt_ff <= 2'd0;
         macc_ff <= 64'd0;
         dcnt_ff <= 7'd0;
         quo_ff  <= d_val;
         rem_ff  <= 64'd0;
      end
      if (state_ff == S_MUL) begin
         mcnt_ff <= mcnt_ff + 2'd1;
         if (mcnt_ff == 2'd0) macc_ff <= macc_ff + mprod;
         else macc_ff <= macc_ff + {mprod[31:0], 32'd0};
      end
      if (state_ff == S_DIV) begin
         dcnt_ff <= dcnt_ff + 7'd1;
         if (!rem_sub[64]) begin
            rem_ff <= rem_sub[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
      if (state_ff == S_EXEC && !(is_muldiv && !started_ff)) begin
         rsp_status       <= st;
         rsp_branch_taken <= tk;
         rsp_pc_step      <= step;
         rsp_call_number  <= cno;
         rsp_return_value <= (wr_en && wr_idx == 4'd0) ? wr_data : r0_ff;
      end
   end
endmodule

>>> verif/ebpf_alu_branch_execute_checker.sv
`timescale 1ns / 1ps
module ebpf_alu_branch_execute_checker #(
   parameter int NUM_REGS = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_op,
   input  logic [7:0]         req_opcode,
   input  logic [3:0]         req_dst_reg,
   input  logic [3:0]         req_src_reg,
   input  logic [15:0]        req_offset,
   input  logic [31:0]        req_immediate,
   input  logic [31:0]        req_immediate_high,
   input  logic [63:0]        req_write_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_branch_taken,
   input  logic [16:0]        rsp_pc_step,
   input  logic [31:0]        rsp_call_number,
   input  logic [63:0]        rsp_return_value,
   output int                 fail_count,
   output int                 pending_count
);
   typedef struct packed {
      logic [1:0]  status;
      logic        taken;
      logic [16:0] step;
      logic [31:0] callno;
      logic [63:0] r0;
   } outcome_type;

   logic [63:0] regs [16];
   outcome_type outcome_q [$];

   function automatic logic reg_valid(logic [3:0] idx);
      return int'(idx) < NUM_REGS;
   endfunction

   // ALU result; ok cleared for an unknown operation
   function automatic logic [63:0] alu_calc(logic [3:0] opr, logic [63:0] d,
                                            logic [63:0] s, output logic ok);
      logic [5:0] sh;
      sh = s[5:0];
      ok = 1'b1;
      case (opr)
         ebpf_pkg::OPR_ADD:  return d + s;
         ebpf_pkg::OPR_SUB:  return d - s;
         ebpf_pkg::OPR_MUL:  return d * s;
         ebpf_pkg::OPR_DIV:  return (s == 0) ? 64'd0 : d / s;
         ebpf_pkg::OPR_OR:   return d | s;
         ebpf_pkg::OPR_AND:  return d & s;
         ebpf_pkg::OPR_LSH:  return d << sh;
         ebpf_pkg::OPR_RSH:  return d >> sh;
         ebpf_pkg::OPR_NEG:  return 64'd0 - d;
         ebpf_pkg::OPR_MOD:  return (s == 0) ? d : d % s;
         ebpf_pkg::OPR_XOR:  return d ^ s;
         ebpf_pkg::OPR_MOV:  return s;
         ebpf_pkg::OPR_ARSH: return $signed(d) >>> sh;
         default: begin
            ok = 1'b0;
            return 64'd0;
         end
      endcase
   endfunction

   // condition: 0/1, 2 for an unknown operation
   function automatic int cond_calc(logic [3:0] opr, logic [63:0] d, logic [63:0] s);
      case (opr)
         ebpf_pkg::JOP_JEQ:  return int'(d == s);
         ebpf_pkg::JOP_JGT:  return int'(d > s);
         ebpf_pkg::JOP_JGE:  return int'(d >= s);
         ebpf_pkg::JOP_JSET: return int'((d & s) != 0);
         ebpf_pkg::JOP_JNE:  return int'(d != s);
         ebpf_pkg::JOP_JSGT: return int'($signed(d) > $signed(s));
         ebpf_pkg::JOP_JSGE: return int'($signed(d) >= $signed(s));
         ebpf_pkg::JOP_JLT:  return int'(d < s);
         ebpf_pkg::JOP_JLE:  return int'(d <= s);
         ebpf_pkg::JOP_JSLT: return int'($signed(d) < $signed(s));
         ebpf_pkg::JOP_JSLE: return int'($signed(d) <= $signed(s));
         default:            return 2;
      endcase
   endfunction

   task automatic execute_instruction();
      outcome_type o;
      logic [2:0]  cls;
      logic [3:0]  opr;
      logic        use_src, ok;
      logic [63:0] d, s, r, imm;
      logic [16:0] off_step;
      int          c;
      o = '0;
      o.status = ebpf_pkg::ST_ILLEGAL;
      cls = req_opcode[2:0];
      opr = req_opcode[7:4];
      use_src = req_opcode[3];
      imm = {{32{req_immediate[31]}}, req_immediate};
      off_step = {req_offset[15], req_offset} + 17'd1;
      if (req_op) begin
         if (reg_valid(req_dst_reg)) begin
            regs[req_dst_reg] = req_write_value;
            o.status = ebpf_pkg::ST_OK;
         end
      end else if (req_opcode == ebpf_pkg::OPC_CALL) begin
         o.status = ebpf_pkg::ST_CALL;
         o.step = 17'd1;
         o.callno = req_immediate;
      end else if (req_opcode == ebpf_pkg::OPC_EXIT) begin
         o.status = ebpf_pkg::ST_EXIT;
      end else if (cls == ebpf_pkg::CLS_JMP && opr == ebpf_pkg::JOP_JA) begin
         o.status = ebpf_pkg::ST_OK;
         o.taken = 1'b1;
         o.step = off_step;
      end else if (cls == ebpf_pkg::CLS_LD) begin
         if (req_opcode == ebpf_pkg::OPC_LDDW && reg_valid(req_dst_reg)) begin
            regs[req_dst_reg] = {req_immediate_high, req_immediate};
            o.status = ebpf_pkg::ST_OK;
            o.step = 17'd2;
         end
      end else if ((cls == ebpf_pkg::CLS_ALU || cls == ebpf_pkg::CLS_ALU64 ||
                    cls == ebpf_pkg::CLS_JMP) &&
                   reg_valid(req_dst_reg) && (!use_src || reg_valid(req_src_reg))) begin
         d = regs[req_dst_reg];
         s = use_src ? regs[req_src_reg] : imm;
         if (cls == ebpf_pkg::CLS_JMP) begin
            c = cond_calc(opr, d, s);
            if (c != 2) begin
               o.status = ebpf_pkg::ST_OK;
               o.taken = c[0];
               o.step = c[0] ? off_step : 17'd1;
            end
         end else begin
            r = alu_calc(opr, d, s, ok);
            if (ok) begin
               if (cls == ebpf_pkg::CLS_ALU) r[63:32] = '0;
               regs[req_dst_reg] = r;
               o.status = ebpf_pkg::ST_OK;
               o.step = 17'd1;
            end
         end
      end
      o.r0 = regs[0];
      outcome_q.push_back(o);
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         for (int i = 0; i < 16; i++) regs[i] = '0;
         outcome_q.delete();
         fail_count <= 0;
      end else begin
         // compare the response first: prediction of this edge's request lands behind it
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected response status=%0d", $time, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               e = outcome_q.pop_front();
               if (e.status !== rsp_status || e.taken !== rsp_branch_taken ||
                   e.step !== rsp_pc_step || e.callno !== rsp_call_number ||
                   e.r0 !== rsp_return_value) begin
                  $display("%0t: mismatch expected st=%0d tk=%0d pc=%h call=%h r0=%h",
                           $time, e.status, e.taken, e.step, e.callno, e.r0);
                  $display("%0t:          actual   st=%0d tk=%0d pc=%h call=%h r0=%h",
                           $time, rsp_status, rsp_branch_taken, rsp_pc_step,
                           rsp_call_number, rsp_return_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) execute_instruction();
      end
      pending_count <= outcome_q.size();
   end
endmodule

>>> verif/ebpf_alu_branch_execute_tb.sv
`timescale 1ns / 1ps
module ebpf_alu_branch_execute_tb;
   localparam int  NUM_ITEMS   = 1050;
   localparam int  CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [7:0]  req_opcode = '0;
   logic [3:0]  req_dst_reg = '0;
   logic [3:0]  req_src_reg = '0;
   logic [15:0] req_offset = '0;
   logic [31:0] req_immediate = '0;
   logic [31:0] req_immediate_high = '0;
   logic [63:0] req_write_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_branch_taken;
   logic [16:0] rsp_pc_step;
   logic [31:0] rsp_call_number;
   logic [63:0] rsp_return_value;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 0;   // sender idle chance, percent
   int          stall_pct = 0;       // receiver stall chance, percent
   int          cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ebpf_alu_branch_execute dut (.*);

   ebpf_alu_branch_execute_checker checker_i (.*);

   // receiver: ready toggles at random independent of valid
   always @(posedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // one transaction: optional idle gap, then hold valid until accepted
   task automatic send_transaction(logic op, logic [7:0] opc, logic [3:0] dst,
                                   logic [3:0] src, logic [15:0] off, logic [31:0] imm,
                                   logic [31:0] immh, logic [63:0] wval);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_opcode <= opc;
      req_dst_reg <= dst;
      req_src_reg <= src;
      req_offset <= off;
      req_immediate <= imm;
      req_immediate_high <= immh;
      req_write_value <= wval;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [63:0] rand_operand();
      case ($urandom_range(5))
         0: return 64'd0;
         1: return {64{1'b1}};
         2: return 64'h8000_0000_0000_0000;
         3: return {32'd0, $urandom()};
         4: return {$urandom_range(3), $urandom_range(65)};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // mostly legal instructions, dst/src mostly in range, some noise opcodes
   task automatic send_random();
      logic [7:0] opc;
      logic [3:0] dst, src;
      logic [2:0] cls;
      dst = ($urandom_range(19) == 0) ? 4'($urandom()) : 4'($urandom_range(10));
      src = ($urandom_range(19) == 0) ? 4'($urandom()) : 4'($urandom_range(10));
      case ($urandom_range(9))
         0: begin
            send_transaction(1'b1, 8'($urandom()), dst, src, 16'($urandom()),
                             $urandom(), $urandom(), rand_operand());
            return;
         end
         1: opc = 8'($urandom());
         2: opc = ($urandom_range(1)) ? ebpf_pkg::OPC_LDDW :
                  (($urandom_range(1)) ? ebpf_pkg::OPC_CALL : ebpf_pkg::OPC_EXIT);
         3, 4, 5: begin
            cls = $urandom_range(1) ? ebpf_pkg::CLS_ALU64 : ebpf_pkg::CLS_ALU;
            opc = {4'($urandom_range(13)), 1'($urandom()), cls};
         end
         default: opc = {4'($urandom_range(13)), 1'($urandom()), ebpf_pkg::CLS_JMP};
      endcase
      send_transaction(1'b0, opc, dst, src, 16'($urandom()),
                       ($urandom_range(3) == 0) ? 32'(rand_operand()) : $urandom(),
                       $urandom(), 64'd0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, illegal indexes, every op, divide by zero
      send_transaction(1'b1, 8'h00, 4'd0, 4'd0, 16'h0, 32'h0, 32'h0, {64{1'b1}});
      send_transaction(1'b1, 8'h00, 4'd10, 4'd0, 16'h0, 32'h0, 32'h0, 64'h8000_0000_0000_0001);
      send_transaction(1'b1, 8'h00, 4'd11, 4'd0, 16'h0, 32'h0, 32'h0, 64'h1234);
      send_transaction(1'b0, ebpf_pkg::OPC_LDDW, 4'd1, 4'd0, 16'h0, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 64'd0);
      send_transaction(1'b0, ebpf_pkg::OPC_LDDW, 4'd15, 4'd0, 16'h0, 32'h8000_0000,
                       32'h0, 64'd0);
      send_transaction(1'b0, {ebpf_pkg::OPR_DIV, 1'b0, ebpf_pkg::CLS_ALU64}, 4'd0, 4'd0,
                       16'h0, 32'h0, 32'h0, 64'd0);
      send_transaction(1'b0, {ebpf_pkg::OPR_MOD, 1'b1, ebpf_pkg::CLS_ALU}, 4'd10, 4'd2,
                       16'h0, 32'h0, 32'h0, 64'd0);
      send_transaction(1'b0, {ebpf_pkg::OPR_ARSH, 1'b0, ebpf_pkg::CLS_ALU64}, 4'd10, 4'd0,
                       16'h0, 32'd127, 32'h0, 64'd0);
      send_transaction(1'b0, {ebpf_pkg::OPR_LSH, 1'b1, ebpf_pkg::CLS_ALU64}, 4'd1, 4'd15,
                       16'h0, 32'h0, 32'h0, 64'd0);
      send_transaction(1'b0, {4'hD, 1'b0, ebpf_pkg::CLS_ALU64}, 4'd1, 4'd0, 16'h0, 32'h0,
                       32'h0, 64'd0);
      send_transaction(1'b0, {ebpf_pkg::JOP_JA, 1'b0, ebpf_pkg::CLS_JMP}, 4'd15, 4'd15,
                       16'h8000, 32'h0, 32'h0, 64'd0);
      send_transaction(1'b0, {ebpf_pkg::JOP_JA, 1'b0, ebpf_pkg::CLS_JMP}, 4'd0, 4'd0,
                       16'h7FFF, 32'h0, 32'h0, 64'd0);
      send_transaction(1'b0, {ebpf_pkg::JOP_JSET, 1'b1, ebpf_pkg::CLS_JMP}, 4'd0, 4'd1,
                       16'hFFFF, 32'h0, 32'h0, 64'd0);
      send_transaction(1'b0, {ebpf_pkg::JOP_JSLT, 1'b0, ebpf_pkg::CLS_JMP}, 4'd10, 4'd0,
                       16'h10, 32'h0, 32'h0, 64'd0);
      send_transaction(1'b0, {4'h8, 1'b0, ebpf_pkg::CLS_JMP}, 4'd0, 4'd0, 16'h0, 32'h0,
                       32'h0, 64'd0);
      send_transaction(1'b0, {4'hE, 1'b1, ebpf_pkg::CLS_JMP}, 4'd0, 4'd0, 16'h0, 32'h0,
                       32'h0, 64'd0);
      send_transaction(1'b0, 8'h06, 4'd0, 4'd0, 16'h0, 32'h0, 32'h0, 64'd0);
      send_transaction(1'b0, ebpf_pkg::OPC_CALL, 4'd15, 4'd15, 16'h0, 32'h8000_0000,
                       32'h0, 64'd0);
      send_transaction(1'b0, ebpf_pkg::OPC_EXIT, 4'd15, 4'd15, 16'h0, 32'h7FFF_FFFF,
                       32'h0, 64'd0);
      for (int i = 0; i < 13; i++)
         send_transaction(1'b0, {4'(i), 1'b1, ebpf_pkg::CLS_ALU64}, 4'd3, 4'd10, 16'h0,
                          32'h0, 32'h0, 64'd0);

      // random, four idling phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
         endcase
         for (int i = 0; i < NUM_ITEMS / 4; i++) send_random();
      end
      req_valid <= 1'b0;

      // drain; pending_count is a registered copy of the queue size
      stall_pct = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

>>> files.f
design/ebpf_pkg.sv
design/ebpf_alu_branch_execute.sv
verif/ebpf_alu_branch_execute_checker.sv
verif/ebpf_alu_branch_execute_tb.sv
